// ----- hdl/cpf_pkg.sv -----
// Package: shared widths, request and result types, and sequencer states for the pair finder.
package cpf_pkg;

  localparam int CFG_W   = 16;            // threshold register width
  localparam int THR_W   = 2 * CFG_W;     // squared threshold width
  localparam int COORD_W = 16;            // coordinate field width on the port
  localparam int IDX_W   = 6;             // index field width on the port

  typedef struct packed {
    logic               restart;
    logic [COORD_W-1:0] coord_0;
    logic [COORD_W-1:0] coord_1;
    logic [COORD_W-1:0] coord_2;
    logic [COORD_W-1:0] coord_3;
  } point_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] later_index;
    logic [IDX_W-1:0] earlier_index;
    logic             is_last;
    logic             overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/cpf_if.sv -----
// Interfaces: valid/ready channels for point requests and pair results.
interface cpf_point_if;
  logic            valid;
  logic            ready;
  cpf_pkg::point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpf_result_if;
  logic             valid;
  logic             ready;
  cpf_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/cpf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module cpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/cpf_lane.sv -----
// Lane: squared difference of one coordinate, registered.
module cpf_lane #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [COORD_BITS-1:0]   a,
  input  logic [COORD_BITS-1:0]   b,
  output logic [2*COORD_BITS:0]   sq
);

  logic signed [COORD_BITS:0]     diff;
  logic signed [2*COORD_BITS+1:0] prod;

  always_comb begin
    diff = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    prod = diff * diff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= prod[2*COORD_BITS:0];   // square is never negative
    end
  end

endmodule

// ----- hdl/cpf_merge.sv -----
// Merge: adds the lane squares and compares with the squared threshold, registered.
module cpf_merge #(
  parameter int DIMS  = 4,
  parameter int SQ_W  = 33,
  parameter int THR_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_W-1:0]  sq [DIMS],
  input  logic [THR_W-1:0] thr,
  output logic             hit
);

  localparam int SUM_W = SQ_W + $clog2(DIMS) + 1;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum = sum + SUM_W'(sq[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= (CMP_W'(sum) < CMP_W'(thr));
    end
  end

endmodule

// ----- hdl/close_pair_finder_top.sv -----
// Top level: close pair finder with lane-parallel distance datapath and pair sequencer.
//
// Each point request is stored and compared with every earlier stored point, lowest index
// first; one result is sent per earlier point whose squared distance lies strictly below
// min_distance squared, the final one flagged is_last. With no close pair a single result
// with found low is sent; a request arriving on a full store gets a single overflow result
// and is dropped, and restart empties the store before the request is taken. The store is
// one point memory with a single read port, read one stored point per cycle when the result
// side keeps up; any stall on the result side stops the whole datapath. One request is
// worked on at a time, but the next is taken while the last result of the previous one
// still waits in the output register. The memory needs no clearing pass: the fill count
// alone says which entries are live. Write min_distance only while the block is idle.
module close_pair_finder_top #(
  parameter int MAX_POINTS = 64,
  parameter int DIMS       = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  cpf_point_if.sink                   points,
  cpf_result_if.source                pairs,
  input  logic                        cfg_we,
  input  logic [cpf_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = DIMS * COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int THR_W  = cpf_pkg::THR_W;
  localparam int IDX_W  = cpf_pkg::IDX_W;

  // control
  cpf_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] count;        // live points in the store
  logic [AW-1:0]    new_idx;      // index given to the request in flight
  logic [AW-1:0]    rd_idx;       // next stored point to read
  logic             ovf;
  logic [THR_W-1:0] thr;          // min_distance squared
  logic             s1_vld, s2_vld, s3_vld;
  logic             pend_vld;     // a hit held back until we know if it is the last
  logic             out_vld;

  // payload
  logic [AW-1:0]         s1_j, s2_j, s3_j, pend_j;
  logic [COORD_BITS-1:0] pt_c [DIMS];
  cpf_pkg::result_t      out_data, emit_data;

  logic                       adv, accept, issue, drained, emit, in_full, s3_hit;
  logic [CNT_W-1:0]           cnt_eff;
  logic [cpf_pkg::COORD_W-1:0] coord_raw [4];
  logic [WORD_W-1:0]          wdata, rdata;
  logic [SQ_W-1:0]            sq [DIMS];

  assign coord_raw[0] = points.data.coord_0;
  assign coord_raw[1] = points.data.coord_1;
  assign coord_raw[2] = points.data.coord_2;
  assign coord_raw[3] = points.data.coord_3;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      wdata[d*COORD_BITS +: COORD_BITS] = coord_raw[d][COORD_BITS-1:0];
    end
  end

  // whole datapath moves only when the output register can take a result
  assign adv          = !out_vld || pairs.ready;
  assign points.ready = (state == cpf_pkg::ST_IDLE);
  assign accept       = points.valid && points.ready;
  assign cnt_eff      = points.data.restart ? '0 : count;
  assign in_full      = (cnt_eff >= CNT_W'(MAX_POINTS));
  assign issue        = (state == cpf_pkg::ST_SCAN) && adv && (rd_idx != new_idx);
  assign drained      = (rd_idx == new_idx) && !s1_vld && !s2_vld && !s3_vld;

  assign pairs.valid = out_vld;
  assign pairs.data  = out_data;

  // sequencer: next state and result selection
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_data  = '0;
    unique case (state)
      cpf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = in_full ? cpf_pkg::ST_FIN : cpf_pkg::ST_SCAN;
        end
      end
      cpf_pkg::ST_SCAN: begin
        if (drained) begin
          state_next = cpf_pkg::ST_FIN;
        end
        // a new hit releases the one held back, which is then not the last
        if (adv && s3_vld && s3_hit && pend_vld) begin
          emit                    = 1'b1;
          emit_data.found         = 1'b1;
          emit_data.later_index   = IDX_W'(new_idx);
          emit_data.earlier_index = IDX_W'(pend_j);
        end
      end
      cpf_pkg::ST_FIN: begin
        if (adv) begin
          emit                  = 1'b1;
          state_next            = cpf_pkg::ST_IDLE;
          emit_data.is_last     = 1'b1;
          emit_data.later_index = IDX_W'(new_idx);
          if (pend_vld) begin
            emit_data.found         = 1'b1;
            emit_data.earlier_index = IDX_W'(pend_j);
          end else begin
            emit_data.overflow = ovf;
          end
        end
      end
      default: begin
        state_next = cpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cpf_pkg::ST_IDLE;
      count    <= '0;
      thr      <= '0;
      out_vld  <= 1'b0;
      pend_vld <= 1'b0;
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      rd_idx   <= '0;
      new_idx  <= '0;
      ovf      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        thr <= THR_W'(cfg_wdata) * THR_W'(cfg_wdata);
      end
      if (emit) begin
        out_vld <= 1'b1;
      end else if (pairs.ready) begin
        out_vld <= 1'b0;
      end
      if (accept) begin
        rd_idx   <= '0;
        pend_vld <= 1'b0;
        if (in_full) begin
          ovf     <= 1'b1;
          new_idx <= '0;
        end else begin
          ovf     <= 1'b0;
          new_idx <= AW'(cnt_eff);
          count   <= cnt_eff + CNT_W'(1);
        end
      end
      if (adv) begin
        s1_vld <= issue;
        s2_vld <= s1_vld;
        s3_vld <= s2_vld;
        if (issue) begin
          rd_idx <= rd_idx + AW'(1);
        end
        if (s3_vld && s3_hit) begin
          pend_vld <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
    if (accept) begin
      for (int d = 0; d < DIMS; d++) begin
        pt_c[d] <= coord_raw[d][COORD_BITS-1:0];
      end
    end
    if (adv) begin
      s1_j <= rd_idx;
      s2_j <= s1_j;
      s3_j <= s2_j;
      if (s3_vld && s3_hit) begin
        pend_j <= s3_j;
      end
    end
  end

  // point store: new point written at its index on an accept that does not overflow, scan reads lower indices only
  cpf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (accept && !in_full),
    .waddr (AW'(cnt_eff)),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    cpf_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk (clk),
      .en  (adv),
      .a   (pt_c[d]),
      .b   (rdata[d*COORD_BITS +: COORD_BITS]),
      .sq  (sq[d])
    );
  end

  cpf_merge #(
    .DIMS  (DIMS),
    .SQ_W  (SQ_W),
    .THR_W (THR_W)
  ) u_merge (
    .clk (clk),
    .en  (adv),
    .sq  (sq),
    .thr (thr),
    .hit (s3_hit)
  );

endmodule

// ----- hdl/cpf_checker.sv -----
// Checker: port-level properties of the pair finder, bound to the top level.
module cpf_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input cpf_pkg::result_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // overflow result is a lone empty result on index 0
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      !out_data.found && out_data.is_last && (out_data.later_index == '0))
    else $error("malformed overflow result");

  // an empty result always closes its request
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.is_last)
    else $error("empty result not marked last");

  // a reported partner was stored earlier
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      (out_data.earlier_index < out_data.later_index) && !out_data.overflow)
    else $error("partner index not below new index");

endmodule

bind close_pair_finder_top cpf_checker u_cpf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pairs.valid),
  .out_ready (pairs.ready),
  .out_data  (pairs.data)
);
